/* hw/rtl/ndcl_pkg.sv */
`timescale 1ns / 1ps
// shared constants and types for the nearest depth cell lookup
package ndcl_pkg;

    localparam int MAX_ENTRIES = 256;

    localparam int DEPTH_W    = 32;
    localparam int CELL_W     = 16;
    localparam int CELL_OUT_W = 17;
    localparam int DIFF_W     = 33;
    localparam int COUNT_W    = 9;
    localparam int TOL_W      = 31;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 31;

    // input commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_TOLERANCE = 1'b1;

    localparam logic [COUNT_W-1:0] ENTRIES_RESET   = '0;
    localparam logic [TOL_W-1:0]   TOLERANCE_RESET = 31'd655360;

    // running best starts at 100000 metres in Q17.16
    localparam logic [DIFF_W-1:0] START_BEST = 33'(64'd100000 << 16);

    localparam logic [CELL_OUT_W-1:0] NOT_FOUND = '1;

    typedef struct packed {
        logic signed [DEPTH_W-1:0] depth;
        logic [CELL_W-1:0]         cell_i;
        logic [CELL_W-1:0]         cell_j;
        logic [CELL_W-1:0]         cell_k;
    } entry_t;

    // search state handed from cell to cell
    typedef struct packed {
        logic              taken;
        logic [DIFF_W-1:0] best;
        logic [CELL_W-1:0] cell_i;
        logic [CELL_W-1:0] cell_j;
        logic [CELL_W-1:0] cell_k;
    } search_tok_t;

endpackage

/* hw/rtl/ndcl_req_if.sv */
`timescale 1ns / 1ps
// request channel: load and query items
interface ndcl_req_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [7:0]         slot;
    logic signed [31:0] depth;
    logic [15:0]        load_cell_i;
    logic [15:0]        load_cell_j;
    logic [15:0]        load_cell_k;

    modport source (
        output valid, cmd, slot, depth, load_cell_i, load_cell_j, load_cell_k,
        input  ready
    );
    modport sink (
        input  valid, cmd, slot, depth, load_cell_i, load_cell_j, load_cell_k,
        output ready
    );
endinterface

/* hw/rtl/ndcl_rsp_if.sv */
`timescale 1ns / 1ps
// response channel: lookup results
interface ndcl_rsp_if;
    logic               valid;
    logic               ready;
    logic               found;
    logic signed [16:0] cell_i_out;
    logic signed [16:0] cell_j_out;
    logic signed [16:0] cell_k_out;

    modport source (
        output valid, found, cell_i_out, cell_j_out, cell_k_out,
        input  ready
    );
    modport sink (
        input  valid, found, cell_i_out, cell_j_out, cell_k_out,
        output ready
    );
endinterface

/* hw/rtl/ndcl_cell.sv */
`timescale 1ns / 1ps
// one table entry plus one compare step of the search chain
module ndcl_cell
    import ndcl_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  entry_t                    wr_entry,
    input  logic                      active,
    input  logic signed [DEPTH_W-1:0] qdepth,
    input  logic                      prev_valid,
    input  search_tok_t               prev_tok,
    output logic                      next_valid,
    output search_tok_t               next_tok
);

    entry_t                    entry_reg;
    logic                      valid_reg;
    search_tok_t               tok_reg;
    search_tok_t               tok_next;
    logic signed [DIFF_W-1:0]  diff;
    logic [DIFF_W-1:0]         abs_diff;
    logic                      take;

    always_comb
    begin
        diff     = DIFF_W'(qdepth) - DIFF_W'(entry_reg.depth);
        abs_diff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        // strict compare keeps the earliest entry on a tie
        take     = active && (abs_diff < prev_tok.best);
        tok_next = prev_tok;
        if (take)
        begin
            tok_next.taken  = 1'b1;
            tok_next.best   = abs_diff;
            tok_next.cell_i = entry_reg.cell_i;
            tok_next.cell_j = entry_reg.cell_j;
            tok_next.cell_k = entry_reg.cell_k;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg <= wr_entry;
        end
        tok_reg <= tok_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= prev_valid;
        end
    end

    assign next_valid = valid_reg;
    assign next_tok   = tok_reg;

endmodule

/* hw/rtl/ndcl_result.sv */
`timescale 1ns / 1ps
// tolerance test at the chain tail and the response output stage
module ndcl_result
    import ndcl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tail_valid,
    input  search_tok_t        tail_tok,
    input  logic [TOL_W-1:0]   tolerance,
    output logic               hold_busy,
    ndcl_rsp_if.source         rsp
);

    logic                  hold_valid_reg;
    logic                  hold_found_reg;
    logic [CELL_W-1:0]     hold_i_reg;
    logic [CELL_W-1:0]     hold_j_reg;
    logic [CELL_W-1:0]     hold_k_reg;
    logic                  out_valid_reg;
    logic                  out_found_reg;
    logic [CELL_OUT_W-1:0] out_i_reg;
    logic [CELL_OUT_W-1:0] out_j_reg;
    logic [CELL_OUT_W-1:0] out_k_reg;
    logic                  match;
    logic                  move;

    assign match = tail_tok.taken && (tail_tok.best < DIFF_W'(tolerance));
    assign move  = hold_valid_reg && (!out_valid_reg || rsp.ready);

    always_ff @(posedge clk)
    begin
        if (tail_valid)
        begin
            hold_found_reg <= match;
            hold_i_reg     <= tail_tok.cell_i;
            hold_j_reg     <= tail_tok.cell_j;
            hold_k_reg     <= tail_tok.cell_k;
        end
        if (move)
        begin
            out_found_reg <= hold_found_reg;
            out_i_reg     <= hold_found_reg ? {1'b0, hold_i_reg} : NOT_FOUND;
            out_j_reg     <= hold_found_reg ? {1'b0, hold_j_reg} : NOT_FOUND;
            out_k_reg     <= hold_found_reg ? {1'b0, hold_k_reg} : NOT_FOUND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // hold is always empty when a new tail item arrives
            if (tail_valid)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (move)
            begin
                hold_valid_reg <= 1'b0;
            end
            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign hold_busy      = hold_valid_reg;
    assign rsp.valid      = out_valid_reg;
    assign rsp.found      = out_found_reg;
    assign rsp.cell_i_out = out_i_reg;
    assign rsp.cell_j_out = out_j_reg;
    assign rsp.cell_k_out = out_k_reg;

endmodule

/* hw/rtl/nearest_depth_cell_lookup.sv */
`timescale 1ns / 1ps
// nearest depth lookup: a query walks a chain of MAX_ENTRIES cells, one cell per cycle
// result path: start register, cell token registers, hold register, output register
// loads are written on accept; no item is accepted while a query walks or its result is held
// reset clears the control state and resets the config registers; table contents are kept
module nearest_depth_cell_lookup
    import ndcl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    ndcl_req_if.sink              req,
    ndcl_rsp_if.source            rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [COUNT_W-1:0]        entries_reg;
    logic [TOL_W-1:0]          tolerance_reg;
    logic                      busy_reg;
    logic                      start_reg;
    logic signed [DEPTH_W-1:0] qdepth_reg;
    logic                      hold_busy;
    logic                      accept;
    logic                      query_go;
    logic                      load_go;
    entry_t                    wr_entry;
    logic                      chain_valid [0:MAX_ENTRIES];
    search_tok_t               chain_tok   [0:MAX_ENTRIES];

    assign req.ready = !busy_reg && !hold_busy;
    assign accept    = req.valid && req.ready;
    assign query_go  = accept && (req.cmd == CMD_QUERY);
    assign load_go   = accept && (req.cmd == CMD_LOAD);

    assign wr_entry.depth  = req.depth;
    assign wr_entry.cell_i = req.load_cell_i;
    assign wr_entry.cell_j = req.load_cell_j;
    assign wr_entry.cell_k = req.load_cell_k;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg   <= ENTRIES_RESET;
            tolerance_reg <= TOLERANCE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENTRIES_IN_USE:  entries_reg   <= cfg_wdata[COUNT_W-1:0];
                CFG_DEPTH_TOLERANCE: tolerance_reg <= cfg_wdata[TOL_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_go)
        begin
            qdepth_reg <= req.depth;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            start_reg <= 1'b0;
        end
        else
        begin
            start_reg <= query_go;
            if (query_go)
            begin
                busy_reg <= 1'b1;
            end
            else if (chain_valid[MAX_ENTRIES])
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // search token entering the head of the chain
    assign chain_valid[0]      = start_reg;
    assign chain_tok[0].taken  = 1'b0;
    assign chain_tok[0].best   = START_BEST;
    assign chain_tok[0].cell_i = '0;
    assign chain_tok[0].cell_j = '0;
    assign chain_tok[0].cell_k = '0;

    for (genvar n = 0; n < MAX_ENTRIES; n++)
    begin : g_cell
        logic wr_en;
        logic active;

        assign wr_en  = load_go && ({24'd0, req.slot} == 32'(n));
        assign active = 32'(n) < {23'd0, entries_reg};

        ndcl_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .wr_en      (wr_en),
            .wr_entry   (wr_entry),
            .active     (active),
            .qdepth     (qdepth_reg),
            .prev_valid (chain_valid[n]),
            .prev_tok   (chain_tok[n]),
            .next_valid (chain_valid[n+1]),
            .next_tok   (chain_tok[n+1])
        );
    end

    ndcl_result u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .tail_valid (chain_valid[MAX_ENTRIES]),
        .tail_tok   (chain_tok[MAX_ENTRIES]),
        .tolerance  (tolerance_reg),
        .hold_busy  (hold_busy),
        .rsp        (rsp)
    );

endmodule

/* hw/rtl/ndcl_checker.sv */
`timescale 1ns / 1ps
// port-level checks for the nearest depth lookup, bound to the top level
module ndcl_checker
    import ndcl_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic req_cmd,
    input logic rsp_valid,
    input logic rsp_ready
);

    // a waiting result is not dropped
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    // an accepted query drops ready
    a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_cmd == CMD_QUERY) |=> !req_ready)
        else $error("item accepted during a query");

    // only an accepted query takes ready low
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(req_ready) |-> $past(req_valid && (req_cmd == CMD_QUERY)))
        else $error("ready fell without a query");

    // a result cannot appear right after a query enters
    a_no_early_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_cmd == CMD_QUERY)
        |-> ##1 !$rose(rsp_valid) ##1 !$rose(rsp_valid))
        else $error("result too early");

endmodule

bind nearest_depth_cell_lookup ndcl_checker u_ndcl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_cmd   (req.cmd),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready)
);

/* tb/nearest_depth_cell_lookup_test.sv */
`timescale 1ns / 1ps
// self-checking testbench for nearest_depth_cell_lookup: table loads, depth queries, config phases
module nearest_depth_cell_lookup_test;
    import ndcl_pkg::*;

    localparam int     SCAN_TAIL   = MAX_ENTRIES + 3;
    localparam int     STALL_LIMIT = 3000;
    localparam longint FAR_BEST    = longint'(100000) <<< 16;

    typedef struct {
        logic                      cmd;
        logic [7:0]                slot;
        logic signed [DEPTH_W-1:0] depth;
        logic [CELL_W-1:0]         cell_i;
        logic [CELL_W-1:0]         cell_j;
        logic [CELL_W-1:0]         cell_k;
    } lookup_req_t;

    typedef struct {
        logic                         found;
        logic signed [CELL_OUT_W-1:0] cell_i;
        logic signed [CELL_OUT_W-1:0] cell_j;
        logic signed [CELL_OUT_W-1:0] cell_k;
    } lookup_rsp_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    ndcl_req_if req_ch ();
    ndcl_rsp_if rsp_ch ();

    nearest_depth_cell_lookup dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predictor copy of the table and registers, updated on accepted items and writes
    logic signed [DEPTH_W-1:0] tab_depth [MAX_ENTRIES];
    logic [CELL_W-1:0]         tab_i [MAX_ENTRIES];
    logic [CELL_W-1:0]         tab_j [MAX_ENTRIES];
    logic [CELL_W-1:0]         tab_k [MAX_ENTRIES];
    logic [COUNT_W-1:0]        scan_count = ENTRIES_RESET;
    logic [TOL_W-1:0]          match_tol  = TOLERANCE_RESET;

    // generator view of the table, used to aim queries near loaded depths
    logic signed [DEPTH_W-1:0] gen_depth [MAX_ENTRIES];
    bit                        gen_written [MAX_ENTRIES];

    lookup_req_t req_backlog [$];
    lookup_rsp_t predicted_rsp [$];
    lookup_req_t nxt;
    lookup_rsp_t want;

    int   queued_items   = 0;
    int   accepted_items = 0;
    int   errors         = 0;
    int   idle_cycles    = 0;
    int   send_gap       = 0;
    int   send_quiet     = 0;
    int   rsp_hold       = 0;
    int   rsp_quiet      = 0;
    logic req_took       = 1'b0;

    function automatic int draw_wait(inout int quiet);
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        // now and then a run of items with no idling at all
        if ($urandom_range(0, 11) == 0)
            quiet = $urandom_range(4, 24);
        return $urandom_range(0, 17);
    endfunction

    function automatic lookup_rsp_t nearest_cell(input logic signed [DEPTH_W-1:0] q);
        lookup_rsp_t res;
        longint      best;
        longint      gap;
        int          hit;
        int          lim;
        best = FAR_BEST;
        hit  = -1;
        lim  = (scan_count > MAX_ENTRIES) ? MAX_ENTRIES : int'(scan_count);
        for (int n = 0; n < lim; n++)
        begin
            gap = longint'(q) - longint'(tab_depth[n]);
            if (gap < 0)
                gap = -gap;
            // strict compare keeps the earliest entry on a tie
            if (gap < best)
            begin
                best = gap;
                hit  = n;
            end
        end
        if (hit >= 0 && best < longint'(match_tol))
        begin
            res.found  = 1'b1;
            res.cell_i = {1'b0, tab_i[hit]};
            res.cell_j = {1'b0, tab_j[hit]};
            res.cell_k = {1'b0, tab_k[hit]};
        end
        else
        begin
            res.found  = 1'b0;
            res.cell_i = NOT_FOUND;
            res.cell_j = NOT_FOUND;
            res.cell_k = NOT_FOUND;
        end
        return res;
    endfunction

    task automatic check_field(input string what, input logic signed [31:0] exp_val,
                               input logic signed [31:0] act_val);
        if (exp_val !== act_val)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, exp_val, act_val);
        end
    endtask

    function automatic void push_load(input logic [7:0] slot, input logic signed [DEPTH_W-1:0] d,
                                      input logic [CELL_W-1:0] ci, input logic [CELL_W-1:0] cj,
                                      input logic [CELL_W-1:0] ck);
        lookup_req_t it;
        it.cmd    = CMD_LOAD;
        it.slot   = slot;
        it.depth  = d;
        it.cell_i = ci;
        it.cell_j = cj;
        it.cell_k = ck;
        req_backlog.push_back(it);
        queued_items++;
        gen_depth[slot]   = d;
        gen_written[slot] = 1'b1;
    endfunction

    function automatic void push_query(input logic signed [DEPTH_W-1:0] d);
        lookup_req_t it;
        it.cmd    = CMD_QUERY;
        it.slot   = 8'($urandom());
        it.depth  = d;
        it.cell_i = 16'($urandom());
        it.cell_j = 16'($urandom());
        it.cell_k = 16'($urandom());
        req_backlog.push_back(it);
        queued_items++;
    endfunction

    function automatic logic signed [DEPTH_W-1:0] pick_depth();
        int r;
        r = $urandom_range(0, MAX_ENTRIES - 1);
        case ($urandom_range(0, 7))
            0, 1: return $urandom();
            2:    if (gen_written[r]) return gen_depth[r];
            default: ;
        endcase
        // clustered within about 256 m of zero so entries sit a few metres apart
        return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    endfunction

    task automatic random_query(input int cnt, input int unsigned tol);
        int     lim;
        longint q;
        lim = (cnt > MAX_ENTRIES) ? MAX_ENTRIES : cnt;
        q   = longint'($signed($urandom()));
        if (lim > 0)
        begin
            q = gen_depth[$urandom_range(0, lim - 1)];
            case ($urandom_range(0, 9))
                0:       q = longint'($signed($urandom()));
                1, 2:    ;
                3, 4, 5: q = q + $urandom_range(0, 131072) - 65536;
                6:       q = q + tol;
                7:       q = q - tol;
                8:       q = q + tol - 1;
                default: q = q - $urandom_range(0, tol);
            endcase
        end
        push_query(q[DEPTH_W-1:0]);
    endtask

    // wait for the block to drain, then for a further full scan length
    task automatic settle();
        while (accepted_items != queued_items || predicted_rsp.size() != 0)
            @(negedge clk);
        repeat (SCAN_TAIL) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic reconfigure(input int cnt, input int unsigned tol);
        settle();
        write_reg(CFG_ENTRIES_IN_USE, CFG_DATA_W'(cnt));
        write_reg(CFG_DEPTH_TOLERANCE, CFG_DATA_W'(tol));
        @(posedge clk);
    endtask

    task automatic random_phase(input int cnt, input int unsigned tol, input int n_items);
        reconfigure(cnt, tol);
        for (int n = 0; n < n_items; n++)
        begin
            if ($urandom_range(0, 9) < 7)
                random_query(cnt, tol);
            else
                push_load(8'($urandom()), pick_depth(), 16'($urandom()), 16'($urandom()),
                          16'($urandom()));
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_took)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                req_ch.valid <= 1'b0;
            end
            else if (req_backlog.size() > 0)
            begin
                nxt = req_backlog.pop_front();
                req_ch.cmd         <= nxt.cmd;
                req_ch.slot        <= nxt.slot;
                req_ch.depth       <= nxt.depth;
                req_ch.load_cell_i <= nxt.cell_i;
                req_ch.load_cell_j <= nxt.cell_j;
                req_ch.load_cell_k <= nxt.cell_k;
                req_ch.valid       <= 1'b1;
                send_gap = draw_wait(send_quiet);
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // result receiver: the stall only counts down while a result is offered
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (rsp_hold > 0)
        begin
            if (rsp_ch.valid)
                rsp_hold--;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // monitor, predictor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_took <= req_ch.valid && req_ch.ready;
            if (cfg_we)
            begin
                if (cfg_index == CFG_ENTRIES_IN_USE)
                    scan_count = cfg_wdata[COUNT_W-1:0];
                else if (cfg_index == CFG_DEPTH_TOLERANCE)
                    match_tol = cfg_wdata[TOL_W-1:0];
            end
            if (req_ch.valid && req_ch.ready)
            begin
                if (req_ch.cmd == CMD_LOAD)
                begin
                    tab_depth[req_ch.slot] = req_ch.depth;
                    tab_i[req_ch.slot]     = req_ch.load_cell_i;
                    tab_j[req_ch.slot]     = req_ch.load_cell_j;
                    tab_k[req_ch.slot]     = req_ch.load_cell_k;
                end
                else
                    predicted_rsp.push_back(nearest_cell(req_ch.depth));
                accepted_items++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (predicted_rsp.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual found %0b cells %0d %0d %0d",
                             $time, rsp_ch.found, rsp_ch.cell_i_out, rsp_ch.cell_j_out,
                             rsp_ch.cell_k_out);
                end
                else
                begin
                    want = predicted_rsp.pop_front();
                    check_field("found", want.found, rsp_ch.found);
                    check_field("cell_i_out", want.cell_i, rsp_ch.cell_i_out);
                    check_field("cell_j_out", want.cell_j, rsp_ch.cell_j_out);
                    check_field("cell_k_out", want.cell_k, rsp_ch.cell_k_out);
                end
                rsp_hold = draw_wait(rsp_quiet);
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_wdata          = '0;
        req_ch.valid       = 1'b0;
        req_ch.cmd         = CMD_LOAD;
        req_ch.slot        = '0;
        req_ch.depth       = '0;
        req_ch.load_cell_i = '0;
        req_ch.load_cell_j = '0;
        req_ch.load_cell_k = '0;
        rsp_ch.ready       = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table at reset values
        push_query(32'sd0);
        push_query(32'sh7FFF_FFFF);
        push_query(32'sh8000_0000);
        // two equal depths for the tie, both depth extremes, field extremes on the last slot
        push_load(8'd0, 32'sd1000, 16'h0000, 16'h0000, 16'h0000);
        push_load(8'd1, 32'sd1000, 16'd1, 16'd2, 16'd3);
        push_load(8'd2, 32'sh7FFF_FFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
        push_load(8'd3, 32'sh8000_0000, 16'h0000, 16'hFFFF, 16'h0000);
        push_load(8'd255, 32'sd5000, 16'hFFFF, 16'hFFFF, 16'hFFFF);

        reconfigure(4, 655360);
        push_query(32'sd2000);
        push_query(32'sd1000 + 32'sd655360);
        push_query(32'sd1000 + 32'sd655359);
        push_query(32'sh7FFF_FFFF);
        push_query(32'sh8000_0000);
        push_query(32'sh4000_0000);

        // zero tolerance never matches
        reconfigure(1, 0);
        push_query(32'sd1000);

        reconfigure(2, 32'h7FFF_FFFF);
        push_query(32'sh7FFF_FFFF);
        push_query(32'sh8000_0000);

        // load every slot so any count can be scanned from here on
        for (int s = 0; s < MAX_ENTRIES; s++)
            push_load(8'(s), pick_depth(), 16'($urandom()), 16'($urandom()), 16'($urandom()));

        random_phase(256, 655360, 40);
        random_phase(511, $urandom_range(1, 32'h0040_0000), 40);
        random_phase(257, 1, 25);
        random_phase(1, 6553600, 25);
        random_phase($urandom_range(2, 255), $urandom_range(0, 32'h7FFF_FFFF), 40);
        random_phase(0, 655360, 12);
        random_phase(256, 32'h7FFF_FFFF, 30);
        random_phase($urandom_range(1, 256), 655360, 40);
        random_phase(128, 0, 15);
        random_phase(256, $urandom_range(0, 32'h0010_0000), 40);

        settle();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/ndcl_pkg.sv
hw/rtl/ndcl_req_if.sv
hw/rtl/ndcl_rsp_if.sv
hw/rtl/ndcl_cell.sv
hw/rtl/ndcl_result.sv
hw/rtl/nearest_depth_cell_lookup.sv
hw/rtl/ndcl_checker.sv
tb/nearest_depth_cell_lookup_test.sv
